/* rtl/pfa_pkg.sv */
`default_nettype none

package pfa_pkg;

    localparam int FRAMES = 1024;
    localparam int IDX_W  = $clog2(FRAMES);
    localparam int LINK_W = $clog2(FRAMES + 1);

    localparam int KIND_W  = 3;
    localparam int OWNER_W = 4;
    localparam int PERMS_W = 32;
    localparam int FIDX_W  = 16;
    localparam int PICK_W  = 10;

    typedef enum logic [1:0] {
        ACT_PICK  = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_ALLOC = 2'd2,
        ACT_FREE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_EMPTY  = 2'd2
    } status_t;

    localparam logic [KIND_W-1:0] KIND_FREE = '0;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
        logic [PERMS_W-1:0] perms;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } entry_wr_t;

endpackage

`default_nettype wire

/* rtl/page_frame_allocator.sv */
`default_nettype none

// Free-list page frame allocator. Each beat on the input carries one action
// (pick, push, allocate, free) and yields exactly one result beat with a
// status and, for a successful pick, the popped frame number. The frame table
// and link memories are read (synchronous read) as the beat is taken; EXEC
// then checks, writes back and updates the list head, waiting while a stalled
// result holds the output register; a new beat is taken while the previous
// result still waits there. After reset a clearing pass over all FRAMES (1024)
// entries initializes the tables; in_stall stays high until it completes.
module page_frame_allocator
    import pfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [FIDX_W-1:0]  frame_index,
    input  wire logic [KIND_W-1:0]  frame_kind,
    input  wire logic [PERMS_W-1:0] access_bits,
    input  wire logic [OWNER_W-1:0] caller_id,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [PICK_W-1:0]       picked_frame
);

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [PICK_W-1:0]  picked_reg, picked_next;

    action_t            act_reg;
    logic [FIDX_W-1:0]  idx_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [PERMS_W-1:0] perms_reg;
    logic [OWNER_W-1:0] caller_reg;
    logic [IDX_W-1:0]   addr_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [LINK_W-1:0]  link_rd;
    entry_t             entry_rd;
    link_wr_t           link_wr;
    entry_wr_t          entry_wr;

    logic accept;
    logic exec_go;
    logic in_range;
    logic list_empty;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign exec_go    = (state_reg == S_EXEC) && !(out_valid_reg && out_stall);
    assign in_range   = 32'(idx_reg) < FRAMES;
    assign list_empty = 32'(head_reg) >= FRAMES;

    // Address the tables straight from the input beat so the read lands in EXEC.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            if (action_t'(action) == ACT_PICK)
            begin
                rd_addr = head_reg[IDX_W-1:0];
            end
            else
            begin
                rd_addr = frame_index[IDX_W-1:0];
            end
        end
        else
        begin
            rd_addr = addr_reg;
        end
    end

    pfa_link_ram u_link_ram (
        .clk     (clk),
        .wr      (link_wr),
        .rd_addr (rd_addr),
        .rd_data (link_rd)
    );

    pfa_entry_ram u_entry_ram (
        .clk     (clk),
        .wr      (entry_wr),
        .rd_addr (rd_addr),
        .rd_data (entry_rd)
    );

    always_comb
    begin
        head_next     = head_reg;
        status_next   = STAT_OK;
        picked_next   = '0;
        link_wr.en    = 1'b0;
        link_wr.addr  = idx_reg[IDX_W-1:0];
        link_wr.data  = head_reg;
        entry_wr.en   = 1'b0;
        entry_wr.addr = idx_reg[IDX_W-1:0];
        entry_wr.data = '0;

        case (act_reg)
            ACT_PICK:
            begin
                if (list_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    picked_next = PICK_W'(head_reg);
                    head_next   = link_rd;
                end
            end
            ACT_PUSH:
            begin
                if (!in_range)
                begin
                    status_next = STAT_REJECT;
                end
                else
                begin
                    link_wr.en = exec_go;
                    head_next  = LINK_W'(idx_reg);
                end
            end
            ACT_ALLOC:
            begin
                if (!in_range || entry_rd.kind != KIND_FREE || kind_reg == KIND_FREE)
                begin
                    status_next = STAT_REJECT;
                end
                else
                begin
                    entry_wr.en   = exec_go;
                    entry_wr.data = '{kind: kind_reg, owner: caller_reg, perms: perms_reg};
                end
            end
            ACT_FREE:
            begin
                if (!in_range || entry_rd.owner != caller_reg)
                begin
                    status_next = STAT_REJECT;
                end
                else
                begin
                    entry_wr.en = exec_go;
                end
            end
            default:
            begin
                status_next = STAT_REJECT;
            end
        endcase

        // Clearing pass: chain every frame to its successor, zero the entries.
        if (state_reg == S_INIT)
        begin
            link_wr.en    = 1'b1;
            link_wr.addr  = clr_cnt_reg;
            link_wr.data  = LINK_W'(clr_cnt_reg) + LINK_W'(1);
            entry_wr.en   = 1'b1;
            entry_wr.addr = clr_cnt_reg;
            entry_wr.data = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (32'(clr_cnt_reg) == FRAMES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INIT)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (exec_go)
            begin
                head_reg      <= head_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action_t'(action);
            idx_reg    <= frame_index;
            kind_reg   <= frame_kind;
            perms_reg  <= access_bits;
            caller_reg <= caller_id;
            addr_reg   <= rd_addr;
        end
        if (exec_go)
        begin
            status_reg <= status_next;
            picked_reg <= picked_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign picked_frame = picked_reg;

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EXEC)
        else $error("accepted beat did not enter execute");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without an executed action");

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |-> in_stall && !out_valid)
        else $error("traffic during clearing pass");

    a_picked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> picked_frame == '0)
        else $error("failed action reported a frame");

    a_no_write_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && out_valid && out_stall |-> !link_wr.en && !entry_wr.en)
        else $error("table written while result is blocked");
`endif

endmodule

`default_nettype wire

/* rtl/pfa_link_ram.sv */
`default_nettype none

module pfa_link_ram
    import pfa_pkg::*;
(
    input  wire logic              clk,
    input  wire link_wr_t          wr,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [LINK_W-1:0] rd_data
);

    logic [LINK_W-1:0] mem [FRAMES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/pfa_entry_ram.sv */
`default_nettype none

module pfa_entry_ram
    import pfa_pkg::*;
(
    input  wire logic             clk,
    input  wire entry_wr_t        wr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [FRAMES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* tb/sv/tb_page_frame_allocator.sv */
`timescale 1ns / 100ps

module tb_page_frame_allocator;
    import pfa_pkg::*;

    localparam int POOL = 48;

    typedef struct packed {
        action_t             act;
        logic [FIDX_W-1:0]   idx;
        logic [KIND_W-1:0]   kind;
        logic [PERMS_W-1:0]  perms;
        logic [OWNER_W-1:0]  caller;
    } frame_req_t;

    typedef struct packed {
        status_t             st;
        logic [PICK_W-1:0]   frame;
    } frame_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [1:0] status;
    logic [PICK_W-1:0] picked_frame;

    frame_req_t cur_req = '0;
    logic [1:0]         action;
    logic [FIDX_W-1:0]  frame_index;
    logic [KIND_W-1:0]  frame_kind;
    logic [PERMS_W-1:0] access_bits;
    logic [OWNER_W-1:0] caller_id;

    assign action      = cur_req.act;
    assign frame_index = cur_req.idx;
    assign frame_kind  = cur_req.kind;
    assign access_bits = cur_req.perms;
    assign caller_id   = cur_req.caller;

    page_frame_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_index  (frame_index),
        .frame_kind   (frame_kind),
        .access_bits  (access_bits),
        .caller_id    (caller_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .picked_frame (picked_frame)
    );

    always #2 clk = ~clk;

    // Shadow of the frame table and free list
    int unsigned        head_ptr;
    int unsigned        link_tbl  [FRAMES];
    logic [KIND_W-1:0]  kind_tbl  [FRAMES];
    logic [OWNER_W-1:0] owner_tbl [FRAMES];
    logic [PERMS_W-1:0] perm_tbl  [FRAMES];

    frame_req_t     req_q[$];
    frame_outcome_t outcome_q[$];
    logic [OWNER_W-1:0] last_caller [POOL];

    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  total_reqs = 0;
    bit  beat_taken = 1'b0;

    function automatic void run_frame_action(frame_req_t r);
        frame_outcome_t o;
        bit fits;
        int unsigned ix;
        o.st = STAT_OK;
        o.frame = '0;
        ix = r.idx;
        fits = (ix < FRAMES);
        case (r.act)
            ACT_PICK:
            begin
                if (head_ptr >= FRAMES)
                begin
                    o.st = STAT_EMPTY;
                end
                else
                begin
                    o.frame = head_ptr[PICK_W-1:0];
                    head_ptr = link_tbl[head_ptr];
                end
            end
            ACT_PUSH:
            begin
                if (!fits)
                begin
                    o.st = STAT_REJECT;
                end
                else
                begin
                    // link first, then move the head
                    link_tbl[ix] = head_ptr;
                    head_ptr = ix;
                end
            end
            ACT_ALLOC:
            begin
                if (!fits || kind_tbl[ix] != KIND_FREE || r.kind == KIND_FREE)
                begin
                    o.st = STAT_REJECT;
                end
                else
                begin
                    kind_tbl[ix] = r.kind;
                    owner_tbl[ix] = r.caller;
                    perm_tbl[ix] = r.perms;
                end
            end
            default:
            begin
                if (!fits || owner_tbl[ix] != r.caller)
                begin
                    o.st = STAT_REJECT;
                end
                else
                begin
                    kind_tbl[ix] = KIND_FREE;
                    owner_tbl[ix] = '0;
                    perm_tbl[ix] = '0;
                end
            end
        endcase
        outcome_q.push_back(o);
    endfunction

    function automatic void queue_action(action_t a, int unsigned ix, int unsigned kd,
                                         logic [PERMS_W-1:0] pm, int unsigned who);
        frame_req_t r;
        r.act = a;
        r.idx = ix[FIDX_W-1:0];
        r.kind = kd[KIND_W-1:0];
        r.perms = pm;
        r.caller = who[OWNER_W-1:0];
        if (a == ACT_ALLOC && ix < POOL)
            last_caller[ix] = r.caller;
        req_q.push_back(r);
        total_reqs++;
    endfunction

    function automatic int unsigned random_frame();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return $urandom_range(0, POOL - 1);
        else if (sel < 9)
            return $urandom_range(0, FRAMES - 1);
        else
            return $urandom_range(FRAMES, 65535);
    endfunction

    task automatic note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned ix;
        int unsigned sel;
        head_ptr = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            link_tbl[i] = i + 1;
            kind_tbl[i] = KIND_FREE;
            owner_tbl[i] = '0;
            perm_tbl[i] = '0;
        end
        for (int i = 0; i < POOL; i++)
            last_caller[i] = '0;

        queue_action(ACT_PICK, 0, 0, 32'h0, 0);
        queue_action(ACT_PUSH, 16'hFFFF, 7, 32'hFFFF_FFFF, 15);
        queue_action(ACT_PUSH, FRAMES, 0, 32'h0, 0);
        queue_action(ACT_PUSH, 0, 0, 32'h0, 0);
        queue_action(ACT_PICK, 0, 0, 32'h0, 0);
        queue_action(ACT_ALLOC, FRAMES - 1, 7, 32'hFFFF_FFFF, 15);
        queue_action(ACT_ALLOC, FRAMES - 1, 1, 32'h1234_5678, 15);
        queue_action(ACT_ALLOC, 5, 0, 32'hFFFF_FFFF, 3);
        queue_action(ACT_ALLOC, FRAMES, 3, 32'h0, 3);
        queue_action(ACT_ALLOC, 16'hFFFF, 3, 32'h0, 3);
        queue_action(ACT_FREE, FRAMES - 1, 0, 32'h0, 14);
        queue_action(ACT_FREE, FRAMES - 1, 0, 32'h0, 15);
        // already free, owner cleared to zero
        queue_action(ACT_FREE, FRAMES - 1, 0, 32'h0, 0);
        queue_action(ACT_FREE, 16'hFFFF, 7, 32'hFFFF_FFFF, 0);
        queue_action(ACT_ALLOC, 7, 4, 32'h0, 0);
        queue_action(ACT_FREE, 7, 0, 32'h0, 0);
        for (int k = 1; k < 8; k++)
            queue_action(ACT_ALLOC, 7 + k, k, k[0] ? 32'hAAAA_AAAA : 32'h5555_5555, k + 8);

        // run of picks down the reset chain, operand fields random
        for (int i = 0; i < 30; i++)
            queue_action(ACT_PICK, $urandom_range(0, 65535), $urandom_range(0, 7),
                         $urandom, $urandom_range(0, 15));
        queue_action(ACT_PUSH, FRAMES - 1, 0, 32'h0, 0);
        queue_action(ACT_PICK, 0, 0, 32'h0, 0);
        queue_action(ACT_PICK, 0, 0, 32'h0, 0);

        for (int n = 0; n < 394; n++)
        begin
            sel = $urandom_range(0, 99);
            ix = random_frame();
            if (sel < 30)
                queue_action(ACT_ALLOC, ix,
                             ($urandom_range(0, 99) < 85) ? $urandom_range(1, 7) : 0,
                             $urandom, $urandom_range(0, 15));
            else if (sel < 60)
                queue_action(ACT_FREE, ix, $urandom_range(0, 7), $urandom,
                             (ix < POOL && $urandom_range(0, 3) != 0) ?
                             last_caller[ix] : $urandom_range(0, 15));
            else if (sel < 80)
                queue_action(ACT_PICK, $urandom_range(0, 65535), $urandom_range(0, 7),
                             $urandom, $urandom_range(0, 15));
            else
                queue_action(ACT_PUSH, ix, $urandom_range(0, 7), $urandom,
                             $urandom_range(0, 15));
        end

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        while (beats_in != total_reqs || outcome_q.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (outcome_q.size() != 0)
            note_error($sformatf("%0d results never arrived", outcome_q.size()));
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Input side: bursts of beats separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || beat_taken)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_q.size() != 0)
            begin
                cur_req <= req_q.pop_front();
                in_valid <= 1'b1;
                burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        beat_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            run_frame_action(cur_req);
            beats_in++;
        end
    end

    // Output side: stall pattern in windows, plus one long hold-off
    int  stall_mode = 0;
    int  window_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && beats_out >= 200)
        begin
            // hold long enough for the block to back up into its input
            hold_done = 1'b1;
            hold_left = 80;
            out_stall <= 1'b1;
        end
        else
        begin
            if (window_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                window_left = $urandom_range(8, 48);
            end
            window_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= window_left[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        frame_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (outcome_q.size() == 0)
            begin
                note_error($sformatf("unexpected result beat: status %0d picked_frame %0d",
                                     status, picked_frame));
            end
            else
            begin
                want = outcome_q.pop_front();
                if (status !== want.st || picked_frame !== want.frame)
                    note_error($sformatf(
                        "beat %0d: status exp %0d got %0d, picked_frame exp %0d got %0d",
                        beats_out, want.st, status, want.frame, picked_frame));
            end
        end
    end

endmodule
